@@ src/gca_pkg.sv @@
// Shared constants and types of the grid cell allocator.
package gca_pkg;

  localparam int MAX_GRID_DIM = 16;
  localparam int MAX_PIXELS   = 4096;
  localparam int STACK_DEPTH  = MAX_GRID_DIM * MAX_GRID_DIM;

  localparam int DIM_W   = $clog2(MAX_GRID_DIM);
  localparam int CNT_W   = $clog2(MAX_GRID_DIM + 1);
  localparam int ADDR_W  = $clog2(STACK_DEPTH);
  localparam int TOP_W   = $clog2(STACK_DEPTH + 1);
  localparam int ENTRY_W = 2 * DIM_W;
  localparam int PIX_W   = $clog2(MAX_PIXELS);
  localparam int SIZE_W  = 13;
  localparam int PROD_W  = DIM_W + SIZE_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int CFG_A_W = 3;

  localparam logic [PIX_W-1:0] PIX_MAX = PIX_W'(MAX_PIXELS - 1);
  localparam logic [TOP_W-1:0] TOP_FULL = TOP_W'(STACK_DEPTH);

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_REBUILD = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_TOO_BIG = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [CFG_A_W-1:0] {
    REG_COLS        = 3'd0,
    REG_ROWS        = 3'd1,
    REG_CELL_WIDTH  = 3'd2,
    REG_CELL_HEIGHT = 3'd3,
    REG_TEX_HEIGHT  = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CALC,
    S_BUILD,
    S_DONE
  } state_t;

endpackage

@@ src/gca_ram.sv @@
// Generic single-port-write, registered-read RAM.
module gca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/grid_cell_allocator.sv @@
// Top level of the grid cell allocator: free stack control and offset math.
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+------------------------------------------
//  in      | input     | in_valid/in_stall   | cmd, req_width, req_height, rel_col, rel_row
//  out     | output    | out_valid/out_stall | status, got_col, got_row, dest_x, dest_y,
//          |           |                  | free_count
//  cfg     | input     | cfg_write        | cfg_addr, cfg_data
//
// One transaction at a time. A successful allocate goes through accept, stack
// memory read, multiply and result; release, failed allocate and unused commands go
// from accept to result. A rebuild makes one stack memory write per cell, and none
// for an empty grid.
// Reset empties the stack; stack memory contents are left as they are.
// A stalled result holds in the output register; the next transaction is accepted
// while it waits, and its own result waits until the register frees.
module grid_cell_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   cmd,
  input  logic [gca_pkg::SIZE_W-1:0]   req_width,
  input  logic [gca_pkg::SIZE_W-1:0]   req_height,
  input  logic [gca_pkg::DIM_W-1:0]    rel_col,
  input  logic [gca_pkg::DIM_W-1:0]    rel_row,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   status,
  output logic [gca_pkg::DIM_W-1:0]    got_col,
  output logic [gca_pkg::DIM_W-1:0]    got_row,
  output logic [gca_pkg::PIX_W-1:0]    dest_x,
  output logic [gca_pkg::PIX_W-1:0]    dest_y,
  output logic [gca_pkg::TOP_W-1:0]    free_count,
  input  logic                         cfg_write,
  input  logic [gca_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [gca_pkg::SIZE_W-1:0]   cfg_data
);
  import gca_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0]  cols_in_use, rows_in_use;
  logic [SIZE_W-1:0] cell_width, cell_height, tex_height;

  logic [TOP_W-1:0]  stack_top;
  logic [DIM_W-1:0]  bx, by;
  logic [SIZE_W-1:0] req_h;
  logic [PROD_W-1:0] prod_w, prod_h;

  status_t           res_status;
  logic [DIM_W-1:0]  res_col, res_row;
  logic [PIX_W-1:0]  res_dx, res_dy;

  logic              accept, out_free;
  logic              alloc_ok;
  status_t           acc_status;
  logic [CNT_W-1:0]  nc, nr;
  logic              last_y, last_x, grid_empty;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic [SUM_W-1:0]  sum_h;
  logic [SUM_W-1:0]  diff_h;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign nc = (cols_in_use > CNT_W'(MAX_GRID_DIM)) ? CNT_W'(MAX_GRID_DIM) : cols_in_use;
  assign nr = (rows_in_use > CNT_W'(MAX_GRID_DIM)) ? CNT_W'(MAX_GRID_DIM) : rows_in_use;
  assign grid_empty = (nc == '0) || (nr == '0);
  assign last_y = ({1'b0, by} == CNT_W'(nr - CNT_W'(1)));
  assign last_x = ({1'b0, bx} == CNT_W'(nc - CNT_W'(1)));

  always_comb begin
    acc_status = ST_OK;
    alloc_ok   = 1'b0;
    case (cmd_t'(cmd))
      CMD_ALLOC: begin
        if (stack_top == '0) begin
          acc_status = ST_EMPTY;
        end else if (req_width > cell_width || req_height > cell_height) begin
          acc_status = ST_TOO_BIG;
        end else begin
          alloc_ok = 1'b1;
        end
      end
      CMD_RELEASE: begin
        if (stack_top == TOP_FULL) begin
          acc_status = ST_FULL;
        end
      end
      default: acc_status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = stack_top[ADDR_W-1:0];
    ram_wdata  = {rel_col, rel_row};
    ram_raddr  = ADDR_W'(stack_top - TOP_W'(1));
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (cmd_t'(cmd))
            CMD_ALLOC: begin
              ram_re     = alloc_ok;
              state_next = alloc_ok ? S_READ : S_DONE;
            end
            CMD_RELEASE: begin
              ram_we     = (acc_status == ST_OK);
              state_next = S_DONE;
            end
            CMD_REBUILD: state_next = S_BUILD;
            default:     state_next = S_DONE;
          endcase
        end
      end
      S_READ: state_next = S_CALC;
      S_CALC: state_next = S_DONE;
      S_BUILD: begin
        ram_wdata = {bx, by};
        if (grid_empty) begin
          state_next = S_DONE;
        end else begin
          ram_we = 1'b1;
          if (last_x && last_y) begin
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= CNT_W'(1);
      rows_in_use <= CNT_W'(1);
      cell_width  <= SIZE_W'(1);
      cell_height <= SIZE_W'(1);
      tex_height  <= SIZE_W'(1);
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_addr))
        REG_COLS:        cols_in_use <= cfg_data[CNT_W-1:0];
        REG_ROWS:        rows_in_use <= cfg_data[CNT_W-1:0];
        REG_CELL_WIDTH:  cell_width  <= cfg_data;
        REG_CELL_HEIGHT: cell_height <= cfg_data;
        REG_TEX_HEIGHT:  tex_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sum_h  = SUM_W'(prod_h) + SUM_W'(req_h);
  assign diff_h = SUM_W'(tex_height) - sum_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_top <= '0;
      bx        <= '0;
      by        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (cmd_t'(cmd))
              CMD_ALLOC: begin
                if (alloc_ok) begin
                  stack_top <= stack_top - TOP_W'(1);
                end
              end
              CMD_RELEASE: begin
                if (acc_status == ST_OK) begin
                  stack_top <= stack_top + TOP_W'(1);
                end
              end
              CMD_REBUILD: begin
                stack_top <= '0;
                bx        <= '0;
                by        <= '0;
              end
              default: ;
            endcase
          end
        end
        S_BUILD: begin
          if (!grid_empty) begin
            stack_top <= stack_top + TOP_W'(1);
            if (last_y) begin
              by <= '0;
              bx <= bx + DIM_W'(1);
            end else begin
              by <= by + DIM_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          res_status <= acc_status;
          res_col    <= '0;
          res_row    <= '0;
          res_dx     <= '0;
          res_dy     <= '0;
          req_h      <= req_height;
        end
      end
      S_READ: begin
        res_col <= ram_rdata[ENTRY_W-1:DIM_W];
        res_row <= ram_rdata[DIM_W-1:0];
        prod_w  <= PROD_W'(ram_rdata[ENTRY_W-1:DIM_W]) * PROD_W'(cell_width);
        prod_h  <= PROD_W'(ram_rdata[DIM_W-1:0]) * PROD_W'(cell_height);
      end
      S_CALC: begin
        res_dx <= (prod_w > PROD_W'(PIX_MAX)) ? PIX_MAX : prod_w[PIX_W-1:0];
        if (sum_h >= SUM_W'(tex_height)) begin
          res_dy <= '0;
        end else if (diff_h > SUM_W'(PIX_MAX)) begin
          res_dy <= PIX_MAX;
        end else begin
          res_dy <= diff_h[PIX_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      status     <= res_status;
      got_col    <= res_col;
      got_row    <= res_row;
      dest_x     <= res_dx;
      dest_y     <= res_dy;
      free_count <= stack_top;
    end
  end

  gca_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

@@ src/gca_checker.sv @@
// Port-level checks of the grid cell allocator, bound to the top level.
module gca_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [1:0]                   status,
  input logic [gca_pkg::DIM_W-1:0]    got_col,
  input logic [gca_pkg::DIM_W-1:0]    got_row,
  input logic [gca_pkg::PIX_W-1:0]    dest_x,
  input logic [gca_pkg::PIX_W-1:0]    dest_y,
  input logic [gca_pkg::TOP_W-1:0]    free_count
);
  import gca_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("transaction accepted while another is in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (free_count <= TOP_FULL))
    else $error("free count beyond stack depth");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |->
      (got_col == '0 && got_row == '0 && dest_x == '0 && dest_y == '0))
    else $error("failed transaction carries cell data");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(free_count)))
    else $error("stalled result changed");

endmodule

bind grid_cell_allocator gca_checker u_gca_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the grid cell allocator: directed script, then random traffic.
module testbench;
  import gca_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int RAND_PHASES = 9;
  localparam int PHASE_ITEMS = 170;
  localparam int SIZE_MAX    = (1 << SIZE_W) - 1;

  typedef struct packed {
    cmd_t              op;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [DIM_W-1:0]  col;
    logic [DIM_W-1:0]  row;
  } grid_req_t;

  typedef struct packed {
    status_t           st;
    logic [DIM_W-1:0]  col;
    logic [DIM_W-1:0]  row;
    logic [PIX_W-1:0]  x;
    logic [PIX_W-1:0]  y;
    logic [TOP_W-1:0]  count;
  } grid_res_t;

  typedef struct {
    bit        is_write;
    reg_idx_t  idx;
    int        data;
    grid_req_t req;
    bit        typed;
    grid_res_t res;
  } script_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         cmd = '0;
  logic [SIZE_W-1:0]  req_width = '0;
  logic [SIZE_W-1:0]  req_height = '0;
  logic [DIM_W-1:0]   rel_col = '0;
  logic [DIM_W-1:0]   rel_row = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic [DIM_W-1:0]   got_col;
  logic [DIM_W-1:0]   got_row;
  logic [PIX_W-1:0]   dest_x;
  logic [PIX_W-1:0]   dest_y;
  logic [TOP_W-1:0]   free_count;
  logic               cfg_write = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr = '0;
  logic [SIZE_W-1:0]  cfg_data = '0;

  logic [ENTRY_W-1:0] free_cells [STACK_DEPTH];
  int                 free_top = 0;
  int                 grid_cols = 1, grid_rows = 1;
  int                 cell_w = 1, cell_h = 1, tex_h = 1;

  grid_res_t   pending_results [$];
  script_row_t script [$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  bit          no_idle = 1'b0;

  grid_cell_allocator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .req_width(req_width), .req_height(req_height),
    .rel_col(rel_col), .rel_row(rel_row),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .got_col(got_col), .got_row(got_row),
    .dest_x(dest_x), .dest_y(dest_y), .free_count(free_count),
    .cfg_write(cfg_write), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic logic [PIX_W-1:0] pix_clamp(int v);
    if (v < 0) return '0;
    if (v > MAX_PIXELS - 1) return PIX_MAX;
    return PIX_W'(v);
  endfunction

  function automatic grid_res_t predict_grid(grid_req_t q);
    grid_res_t r;
    logic [ENTRY_W-1:0] e;
    int nc, nr;
    r.st = ST_OK;
    r.col = '0;
    r.row = '0;
    r.x = '0;
    r.y = '0;
    case (q.op)
      CMD_ALLOC: begin
        if (free_top == 0) begin
          r.st = ST_EMPTY;
        end else if (q.width > cell_w || q.height > cell_h) begin
          r.st = ST_TOO_BIG;
        end else begin
          free_top--;
          e = free_cells[free_top];
          r.col = e[ENTRY_W-1:DIM_W];
          r.row = e[DIM_W-1:0];
          r.x = pix_clamp(int'(r.col) * cell_w);
          r.y = pix_clamp(tex_h - int'(r.row) * cell_h - int'(q.height));
        end
      end
      CMD_RELEASE: begin
        if (free_top >= STACK_DEPTH) begin
          r.st = ST_FULL;
        end else begin
          free_cells[free_top] = {q.col, q.row};
          free_top++;
        end
      end
      CMD_REBUILD: begin
        nc = (grid_cols > MAX_GRID_DIM) ? MAX_GRID_DIM : grid_cols;
        nr = (grid_rows > MAX_GRID_DIM) ? MAX_GRID_DIM : grid_rows;
        free_top = 0;
        for (int cx = 0; cx < nc; cx++) begin
          for (int ry = 0; ry < nr; ry++) begin
            free_cells[free_top] = {DIM_W'(cx), DIM_W'(ry)};
            free_top++;
          end
        end
      end
      default: ;
    endcase
    r.count = TOP_W'(free_top);
    return r;
  endfunction

  function automatic grid_req_t make_req(cmd_t op, int w, int h, int rc, int rr);
    grid_req_t q;
    q.op = op;
    q.width = w[SIZE_W-1:0];
    q.height = h[SIZE_W-1:0];
    q.col = rc[DIM_W-1:0];
    q.row = rr[DIM_W-1:0];
    return q;
  endfunction

  function automatic void add_row(cmd_t op, int w, int h, int rc, int rr,
                                  bit typed, status_t st, int cnt);
    script_row_t s;
    s.is_write = 1'b0;
    s.idx = REG_COLS;
    s.data = 0;
    s.req = make_req(op, w, h, rc, rr);
    s.typed = typed;
    s.res = '0;
    s.res.st = st;
    s.res.count = TOP_W'(cnt);
    script.insert(script.size(), s);
  endfunction

  function automatic void add_write(reg_idx_t r, int v);
    script_row_t s;
    s.is_write = 1'b1;
    s.idx = r;
    s.data = v;
    s.req = '0;
    s.typed = 1'b0;
    s.res = '0;
    script.insert(script.size(), s);
  endfunction

  function automatic int pick_dim();
    int k;
    k = $urandom_range(9);
    if (k < 5) return $urandom_range(1, 6);
    if (k == 5) return MAX_GRID_DIM;
    if (k == 6) return 0;
    if (k == 7) return $urandom_range(MAX_GRID_DIM + 1, 31);
    return $urandom_range(1, MAX_GRID_DIM);
  endfunction

  function automatic int pick_size();
    int k;
    k = $urandom_range(9);
    if (k < 3) return $urandom_range(1, 64);
    if (k == 3) return SIZE_MAX;
    if (k == 4) return 0;
    if (k == 5) return MAX_PIXELS;
    return $urandom_range(0, SIZE_MAX);
  endfunction

  function automatic grid_req_t random_req();
    int k, w, h, rc, rr;
    k = $urandom_range(99);
    w = $urandom_range(0, SIZE_MAX);
    h = $urandom_range(0, SIZE_MAX);
    rc = $urandom_range(0, 15);
    rr = $urandom_range(0, 15);
    if (k < 46) begin
      k = $urandom_range(9);
      if (k < 6) begin
        w = $urandom_range(0, cell_w);
        h = $urandom_range(0, cell_h);
      end else if (k < 8) begin
        w = (cell_w + $urandom_range(0, 1)) & SIZE_MAX;
        h = (cell_h + $urandom_range(0, 1)) & SIZE_MAX;
      end
      return make_req(CMD_ALLOC, w, h, rc, rr);
    end
    if (k < 86) return make_req(CMD_RELEASE, w, h, rc, rr);
    if (k < 93) return make_req(CMD_REBUILD, w, h, rc, rr);
    return make_req(CMD_NONE, w, h, rc, rr);
  endfunction

  task automatic send_request(input grid_req_t q, input bit typed, input grid_res_t typed_res);
    grid_res_t predicted;
    in_valid <= 1'b1;
    cmd <= q.op;
    req_width <= q.width;
    req_height <= q.height;
    rel_col <= q.col;
    rel_row <= q.row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_grid(q);
    pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, int v);
    cfg_write <= 1'b1;
    cfg_addr <= r;
    cfg_data <= v[SIZE_W-1:0];
    @(posedge clk);
    case (r)
      REG_COLS:        grid_cols = v & 31;
      REG_ROWS:        grid_rows = v & 31;
      REG_CELL_WIDTH:  cell_w = v & SIZE_MAX;
      REG_CELL_HEIGHT: cell_h = v & SIZE_MAX;
      REG_TEX_HEIGHT:  tex_h = v & SIZE_MAX;
      default: ;
    endcase
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99) < 22);
  end

  always @(posedge clk) begin : result_monitor
    grid_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual status %0d", $time, status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.st, status);
        check_field("got_col", want.col, got_col);
        check_field("got_row", want.row, got_row);
        check_field("dest_x", want.x, dest_x);
        check_field("dest_y", want.y, dest_y);
        check_field("free_count", want.count, free_count);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("grid_cell_allocator test failed");
      $finish;
    end
  end

  initial begin
    int vals [5];
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset grid: one 1x1 cell, stack empty
    add_row(CMD_ALLOC, 1, 1, 0, 0, 1, ST_EMPTY, 0);
    add_row(CMD_ALLOC, SIZE_MAX, SIZE_MAX, 0, 0, 1, ST_EMPTY, 0);
    add_row(CMD_NONE, SIZE_MAX, SIZE_MAX, 15, 15, 1, ST_OK, 0);
    add_row(CMD_RELEASE, 0, 0, 15, 15, 1, ST_OK, 1);
    add_row(CMD_ALLOC, 2, 1, 0, 0, 1, ST_TOO_BIG, 1);
    add_row(CMD_ALLOC, 1, 2, 0, 0, 1, ST_TOO_BIG, 1);
    add_row(CMD_ALLOC, 1, 1, 0, 0, 0, ST_OK, 0);
    add_row(CMD_REBUILD, 0, 0, 0, 0, 1, ST_OK, 1);
    add_row(CMD_ALLOC, 0, 0, 0, 0, 0, ST_OK, 0);
    // saturated grid, widest sizes
    add_write(REG_COLS, 31);
    add_write(REG_ROWS, MAX_GRID_DIM);
    add_write(REG_CELL_WIDTH, SIZE_MAX);
    add_write(REG_CELL_HEIGHT, SIZE_MAX);
    add_write(REG_TEX_HEIGHT, SIZE_MAX);
    add_row(CMD_REBUILD, 0, 0, 0, 0, 1, ST_OK, STACK_DEPTH);
    add_row(CMD_RELEASE, 0, 0, 0, 0, 1, ST_FULL, STACK_DEPTH);
    add_row(CMD_ALLOC, SIZE_MAX, SIZE_MAX, 0, 0, 0, ST_OK, 0);
    add_row(CMD_RELEASE, 0, 0, 0, 0, 0, ST_OK, 0);
    add_row(CMD_ALLOC, 0, 0, 0, 0, 0, ST_OK, 0);
    // empty grid, then zero cell width
    add_write(REG_COLS, 0);
    add_row(CMD_REBUILD, 0, 0, 0, 0, 1, ST_OK, 0);
    add_row(CMD_ALLOC, 0, 0, 0, 0, 1, ST_EMPTY, 0);
    add_write(REG_CELL_WIDTH, 0);
    add_write(REG_COLS, 1);
    add_row(CMD_REBUILD, 0, 0, 0, 0, 0, ST_OK, 0);
    add_row(CMD_ALLOC, 1, 0, 0, 0, 1, ST_TOO_BIG, MAX_GRID_DIM);
    add_row(CMD_ALLOC, 0, 5, 0, 0, 0, ST_OK, 0);

    foreach (script[i]) begin
      if (script[i].is_write) begin
        drain_block();
        write_reg(script[i].idx, script[i].data);
        cfg_write <= 1'b0;
      end else begin
        send_request(script[i].req, script[i].typed, script[i].res);
      end
    end

    for (int p = 1; p <= RAND_PHASES; p++) begin
      drain_block();
      no_idle = (p == 4);
      if (p == 1) begin
        vals = '{31, 31, SIZE_MAX, SIZE_MAX, SIZE_MAX};
      end else if (p == 2) begin
        vals = '{0, 0, 0, 0, 0};
      end else begin
        vals[0] = pick_dim();
        vals[1] = pick_dim();
        vals[2] = pick_size();
        vals[3] = pick_size();
        vals[4] = pick_size();
      end
      for (int i = 0; i < 5; i++) write_reg(reg_idx_t'(i), vals[i]);
      cfg_write <= 1'b0;
      send_request(make_req(CMD_REBUILD, 0, 0, 0, 0), 1'b0, '0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (!no_idle && $urandom_range(99) < 22) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        send_request(random_req(), 1'b0, '0);
      end
    end
    no_idle = 1'b0;

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("grid_cell_allocator test passed");
    end else begin
      $display("grid_cell_allocator test failed");
    end
    $finish;
  end

endmodule
